// ===== src/jlpg_pkg.sv =====
`timescale 1ns / 1ps
package jlpg_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_JERK_MAX = 3'd0,
        REG_ACC_MAX  = 3'd1,
        REG_VEL_MAX  = 3'd2,
        REG_DISTANCE = 3'd3,
        REG_RAMP     = 3'd4,
        REG_CRUISE   = 3'd5,
        REG_TOTAL    = 3'd6
    } reg_idx_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_RAMP   = 9'b000000100,
        S_COMB   = 9'b000001000,
        S_ACC_A  = 9'b000010000,
        S_ACC_V  = 9'b000100000,
        S_ACC_P  = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_SPARE  = 9'b100000000
    } ctrl_state_t;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_DIV  = 4'b0100,
        M_DONE = 4'b1000
    } md_state_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic comb;
        logic acc_a;
        logic acc_v;
        logic acc_p;
        logic load_out;
    } jlpg_cmd_t;

    typedef struct packed {
        logic restart;
        logic running;
        logic is_last;
        logic need_ramp;
        logic ramp_done;
        logic out_free;
    } jlpg_sts_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W-1:0] s;
        s = a + b;
        if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
            s = a[DATA_W-1] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W-1:0] s;
        s = a - b;
        if (a[DATA_W-1] != b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
            s = a[DATA_W-1] ? SMIN : SMAX;
        return s;
    endfunction

endpackage

// ===== src/jlpg_muldiv.sv =====
`timescale 1ns / 1ps
module jlpg_muldiv #(
    parameter int COUNT_BITS = jlpg_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [jlpg_pkg::DATA_W-1:0]  jerk_max,
    input  logic [COUNT_BITS-1:0]               e,
    input  logic [COUNT_BITS-1:0]               d,
    output logic                                done,
    output logic signed [jlpg_pkg::DATA_W-1:0]  r
);
    import jlpg_pkg::*;

    localparam int PW = DATA_W + COUNT_BITS;
    localparam int QW = PW + 2;
    localparam int SW = $clog2(QW + 1);

    md_state_t              st_reg;
    logic [SW-1:0]          step_reg;
    logic                   neg_reg;
    logic                   dz_reg;
    logic [COUNT_BITS-1:0]  e_reg;
    logic [COUNT_BITS-1:0]  d_reg;
    logic [PW-1:0]          mc_reg;
    logic [PW-1:0]          prod_reg;
    logic [QW-1:0]          num_reg;
    logic [COUNT_BITS-1:0]  rem_reg;

    logic [DATA_W-1:0]      mag;
    logic [PW-1:0]          prod_next;
    logic [COUNT_BITS:0]    shifted;
    logic [COUNT_BITS+1:0]  diff;
    logic                   qbit;
    logic [DATA_W-1:0]      lo;

    assign mag       = jerk_max[DATA_W-1] ? (DATA_W'(0) - jerk_max) : jerk_max;
    assign prod_next = e_reg[0] ? (prod_reg + mc_reg) : prod_reg;
    assign shifted   = {rem_reg, num_reg[QW-1]};
    assign diff      = {1'b0, shifted} - {2'b00, d_reg};
    assign qbit      = !diff[COUNT_BITS+1];
    assign lo        = num_reg[DATA_W-1:0];
    assign done      = (st_reg == M_DONE);

    always_comb
    begin
        if (dz_reg)
            r = '0;
        else if (neg_reg)
        begin
            if (num_reg[QW-1:DATA_W] != '0 || lo > DATA_W'(SMIN))
                r = SMIN;
            else
                r = DATA_W'(0) - lo;
        end
        else if (num_reg[QW-1:DATA_W-1] != '0)
            r = SMAX;
        else
            r = lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= M_IDLE;
            step_reg <= '0;
        end
        else
        begin
            case (st_reg)
                M_IDLE:
                begin
                    step_reg <= '0;
                    if (start)
                        st_reg <= M_MUL;
                end
                M_MUL:
                begin
                    if (step_reg == SW'(COUNT_BITS - 1))
                    begin
                        step_reg <= '0;
                        st_reg   <= M_DIV;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                M_DIV:
                begin
                    if (step_reg == SW'(QW - 1))
                    begin
                        step_reg <= '0;
                        st_reg   <= M_DONE;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                M_DONE:
                    st_reg <= M_IDLE;
                default:
                    st_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= jerk_max[DATA_W-1];
                    dz_reg   <= (d == '0);
                    e_reg    <= e;
                    d_reg    <= d;
                    mc_reg   <= {{COUNT_BITS{1'b0}}, mag};
                    prod_reg <= '0;
                end
            end
            M_MUL:
            begin
                prod_reg <= prod_next;
                mc_reg   <= {mc_reg[PW-2:0], 1'b0};
                e_reg    <= {1'b0, e_reg[COUNT_BITS-1:1]};
                if (step_reg == SW'(COUNT_BITS - 1))
                begin
                    num_reg <= {prod_next, 2'b00};
                    rem_reg <= '0;
                end
            end
            M_DIV:
            begin
                rem_reg <= qbit ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
                num_reg <= {num_reg[QW-2:0], qbit};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== src/jlpg_datapath.sv =====
`timescale 1ns / 1ps
module jlpg_datapath #(
    parameter int COUNT_BITS = jlpg_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jlpg_pkg::jlpg_cmd_t                 cmd,
    output jlpg_pkg::jlpg_sts_t                 sts,
    input  logic                                restart,
    input  logic signed [jlpg_pkg::DATA_W-1:0]  jerk_max,
    input  logic signed [jlpg_pkg::DATA_W-1:0]  acc_max,
    input  logic signed [jlpg_pkg::DATA_W-1:0]  vel_max,
    input  logic signed [jlpg_pkg::DATA_W-1:0]  distance,
    input  logic [COUNT_BITS-1:0]               ramp_samples,
    input  logic [COUNT_BITS-1:0]               cruise_samples,
    input  logic [COUNT_BITS-1:0]               total_samples,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [COUNT_BITS-1:0]               sample_index,
    output logic signed [jlpg_pkg::DATA_W-1:0]  jerk,
    output logic signed [jlpg_pkg::DATA_W-1:0]  accel,
    output logic signed [jlpg_pkg::DATA_W-1:0]  velocity,
    output logic signed [jlpg_pkg::DATA_W-1:0]  position,
    output logic                                last
);
    import jlpg_pkg::*;

    localparam int BW = COUNT_BITS + 2;

    logic [COUNT_BITS-1:0]     cnt_reg;
    logic                      run_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  aacc_reg, vacc_reg, pacc_reg;
    logic signed [DATA_W-1:0]  j_reg, a_reg, v_reg, p_reg;
    logic                      last_reg;
    logic signed [DATA_W-1:0]  base_reg;
    logic                      sub_reg, use_r_reg, fpos_reg, fneg_reg, cruise_reg;
    logic [COUNT_BITS-1:0]     o_idx_reg;
    logic signed [DATA_W-1:0]  o_j_reg, o_a_reg, o_v_reg, o_p_reg;
    logic                      o_last_reg;

    logic [BW-1:0]             t, tt, q1, q2, n1, z, n3, n4, p3, p4, off;
    logic signed [DATA_W-1:0]  nj, base_next, rterm, rsel, a_next;
    logic                      is_last, need_ramp, sub_next, fpos_next, fneg_next, cruise_next;
    logic                      md_done;
    logic [COUNT_BITS-1:0]     e_val;

    assign nj = sat_sub(DATA_W'(0), jerk_max);

    always_comb
    begin
        t    = BW'(cnt_reg);
        tt   = BW'(ramp_samples);
        q1   = tt >> 2;
        q2   = tt >> 1;
        n1   = (q1 << 1) + q1;
        z    = tt + BW'(cruise_samples);
        n3   = z + q1;
        n4   = z + q2;
        p3   = z + n1;
        p4   = z + tt;
        is_last     = (cnt_reg == total_samples);
        need_ramp   = 1'b0;
        base_next   = '0;
        sub_next    = 1'b0;
        fpos_next   = 1'b0;
        fneg_next   = 1'b0;
        cruise_next = 1'b0;
        off         = '0;
        if (is_last)
        begin
        end
        else if (t < q1)
            need_ramp = 1'b1;
        else if (t == q1)
            base_next = jerk_max;
        else if (t < q2)
        begin
            need_ramp = 1'b1; base_next = jerk_max; sub_next = 1'b1; off = q1;
        end
        else if (t == q2)
            fpos_next = 1'b1;
        else if (t < n1)
        begin
            need_ramp = 1'b1; sub_next = 1'b1; off = q2;
        end
        else if (t == n1)
            base_next = nj;
        else if (t < tt)
        begin
            need_ramp = 1'b1; base_next = nj; off = n1;
        end
        else if (t <= z)
            cruise_next = 1'b1;
        else if (t < n3)
        begin
            need_ramp = 1'b1; sub_next = 1'b1; off = z;
        end
        else if (t == n3)
            base_next = nj;
        else if (t < n4)
        begin
            need_ramp = 1'b1; base_next = nj; off = n3;
        end
        else if (t == n4)
            fneg_next = 1'b1;
        else if (t < p3)
        begin
            need_ramp = 1'b1; off = n4;
        end
        else if (t == p3)
            base_next = jerk_max;
        else if (t < p4)
        begin
            need_ramp = 1'b1; base_next = jerk_max; sub_next = 1'b1; off = p3;
        end
        e_val = COUNT_BITS'(t - off);
    end

    jlpg_muldiv #(
        .COUNT_BITS (COUNT_BITS)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.decode && need_ramp && !is_last),
        .jerk_max (jerk_max),
        .e        (e_val),
        .d        (ramp_samples),
        .done     (md_done),
        .r        (rterm)
    );

    assign rsel = use_r_reg ? rterm : '0;

    always_comb
    begin
        if (cruise_reg)
            a_next = '0;
        else if (fpos_reg)
            a_next = acc_max;
        else if (fneg_reg)
            a_next = sat_sub(DATA_W'(0), acc_max);
        else
            a_next = sat_add(aacc_reg, j_reg);
    end

    assign sts.restart   = restart;
    assign sts.running   = run_reg;
    assign sts.is_last   = is_last;
    assign sts.need_ramp = need_ramp;
    assign sts.ramp_done = md_done;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            aacc_reg      <= '0;
            vacc_reg      <= '0;
            pacc_reg      <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (restart)
                begin
                    cnt_reg  <= '0;
                    run_reg  <= (total_samples != '0);
                    aacc_reg <= '0;
                    vacc_reg <= '0;
                    pacc_reg <= '0;
                end
                else if (run_reg)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.decode && is_last)
            begin
                run_reg  <= 1'b0;
                aacc_reg <= '0;
                vacc_reg <= '0;
                pacc_reg <= distance;
            end
            if (cmd.acc_p)
            begin
                aacc_reg <= a_reg;
                vacc_reg <= v_reg;
                pacc_reg <= sat_add(pacc_reg, v_reg);
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            j_reg    <= '0;
            a_reg    <= '0;
            v_reg    <= '0;
            p_reg    <= '0;
            last_reg <= (total_samples == '0);
        end
        if (cmd.decode)
        begin
            if (is_last)
            begin
                j_reg    <= '0;
                a_reg    <= '0;
                v_reg    <= '0;
                p_reg    <= distance;
                last_reg <= 1'b1;
            end
            else
                last_reg <= 1'b0;
            base_reg   <= base_next;
            sub_reg    <= sub_next;
            use_r_reg  <= need_ramp;
            fpos_reg   <= fpos_next;
            fneg_reg   <= fneg_next;
            cruise_reg <= cruise_next;
        end
        if (cmd.comb)
            j_reg <= sub_reg ? sat_sub(base_reg, rsel) : sat_add(base_reg, rsel);
        if (cmd.acc_a)
            a_reg <= a_next;
        if (cmd.acc_v)
            v_reg <= cruise_reg ? vel_max : sat_add(vacc_reg, a_reg);
        if (cmd.acc_p)
            p_reg <= sat_add(pacc_reg, v_reg);
        if (cmd.load_out)
        begin
            o_idx_reg  <= cnt_reg;
            o_j_reg    <= j_reg;
            o_a_reg    <= a_reg;
            o_v_reg    <= v_reg;
            o_p_reg    <= p_reg;
            o_last_reg <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = o_idx_reg;
    assign jerk         = o_j_reg;
    assign accel        = o_a_reg;
    assign velocity     = o_v_reg;
    assign position     = o_p_reg;
    assign last         = o_last_reg;

endmodule

// ===== src/jlpg_ctrl.sv =====
`timescale 1ns / 1ps
module jlpg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  jlpg_pkg::jlpg_sts_t  sts,
    output jlpg_pkg::jlpg_cmd_t  cmd
);
    import jlpg_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (sts.restart)
                        state_next = S_OUT;
                    else if (sts.running)
                        state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.is_last)
                    state_next = S_OUT;
                else if (sts.need_ramp)
                    state_next = S_RAMP;
                else
                    state_next = S_COMB;
            end
            S_RAMP:
            begin
                if (sts.ramp_done)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = S_ACC_A;
            end
            S_ACC_A:
            begin
                cmd.acc_a  = 1'b1;
                state_next = S_ACC_V;
            end
            S_ACC_V:
            begin
                cmd.acc_v  = 1'b1;
                state_next = S_ACC_P;
            end
            S_ACC_P:
            begin
                cmd.acc_p  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_ramp_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.ramp_done |-> state_reg == S_RAMP)
        else $error("ramp unit finished outside the wait state");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten");
`endif

endmodule

// ===== src/jerk_limited_profile_generator_core.sv =====
`timescale 1ns / 1ps
// Channel | Handshake           | Payload
// in      | in_valid, in_ready  | restart
// out     | out_valid, out_ready| sample_index, jerk, accel, velocity, position, last
// apb     | psel, penable, pwrite, pready | paddr, pwdata, prdata (8-byte registers)
// Restart transfer: accept goes to S_OUT, which loads the output register when free.
// Sample without ramp term: IDLE, DECODE, COMB, ACC_A, ACC_V, ACC_P, OUT; last: IDLE, DECODE, OUT.
// Ramp sample: the controller waits in S_RAMP for the ramp term from the serial
// shift-add multiplier and restoring divider.
// rst_n asynchronously resets controller, counter, accumulators and config registers.
// One item at a time; a full output register stalls the controller before load.
module jerk_limited_profile_generator_core #(
    parameter int COUNT_BITS = jlpg_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jlpg_pkg::ADDR_W-1:0]         paddr,
    input  logic [jlpg_pkg::DATA_W-1:0]         pwdata,
    output logic [jlpg_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [COUNT_BITS-1:0]               sample_index,
    output logic signed [jlpg_pkg::DATA_W-1:0]  jerk,
    output logic signed [jlpg_pkg::DATA_W-1:0]  accel,
    output logic signed [jlpg_pkg::DATA_W-1:0]  velocity,
    output logic signed [jlpg_pkg::DATA_W-1:0]  position,
    output logic                                last
);
    import jlpg_pkg::*;

    logic signed [DATA_W-1:0]  jerk_max_reg, acc_max_reg, vel_max_reg, distance_reg;
    logic [COUNT_BITS-1:0]     ramp_reg, cruise_reg, total_reg;
    logic                      wr;
    reg_idx_t                  idx;
    jlpg_cmd_t                 cmd;
    jlpg_sts_t                 sts;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jerk_max_reg <= '0;
            acc_max_reg  <= '0;
            vel_max_reg  <= '0;
            distance_reg <= '0;
            ramp_reg     <= COUNT_BITS'(4);
            cruise_reg   <= '0;
            total_reg    <= COUNT_BITS'(1);
        end
        else if (wr)
        begin
            case (idx)
                REG_JERK_MAX: jerk_max_reg <= pwdata;
                REG_ACC_MAX:  acc_max_reg  <= pwdata;
                REG_VEL_MAX:  vel_max_reg  <= pwdata;
                REG_DISTANCE: distance_reg <= pwdata;
                REG_RAMP:     ramp_reg     <= pwdata[COUNT_BITS-1:0];
                REG_CRUISE:   cruise_reg   <= pwdata[COUNT_BITS-1:0];
                REG_TOTAL:    total_reg    <= pwdata[COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_JERK_MAX: prdata = jerk_max_reg;
            REG_ACC_MAX:  prdata = acc_max_reg;
            REG_VEL_MAX:  prdata = vel_max_reg;
            REG_DISTANCE: prdata = distance_reg;
            REG_RAMP:     prdata = DATA_W'(ramp_reg);
            REG_CRUISE:   prdata = DATA_W'(cruise_reg);
            REG_TOTAL:    prdata = DATA_W'(total_reg);
            default:      prdata = '0;
        endcase
    end

    jlpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jlpg_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .restart        (restart),
        .jerk_max       (jerk_max_reg),
        .acc_max        (acc_max_reg),
        .vel_max        (vel_max_reg),
        .distance       (distance_reg),
        .ramp_samples   (ramp_reg),
        .cruise_samples (cruise_reg),
        .total_samples  (total_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_index   (sample_index),
        .jerk           (jerk),
        .accel          (accel),
        .velocity       (velocity),
        .position       (position),
        .last           (last)
    );

endmodule
